// ----- rtl/core/vector_angle_unit_assert.svh -----
// Assertion macros shared by the vector angle unit RTL.
`ifndef VECTOR_ANGLE_UNIT_ASSERT_SVH
`define VECTOR_ANGLE_UNIT_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define VAU_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a trigger implies a consequence in the same cycle.
`define VAU_ASSERT_IMPL(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/vau_pkg.sv -----
// Types and constants of the vector angle unit.
package vau_pkg;

  // One request: two vectors in signed Q8.8.
  typedef struct packed {
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_z;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] second_z;
  } vau_req_t;

  // One response: angle in unsigned Q2.14 radians and the degenerate flag.
  typedef struct packed {
    logic [15:0] angle;
    logic        degenerate;
  } vau_rsp_t;

  localparam int unsigned CordicSteps = 20;
  localparam int unsigned CosW        = 15;
  localparam logic [14:0] CosOne      = 15'd16384;
  localparam logic signed [27:0] PiAng = 28'sd52707179;
  localparam logic [17:0] AngleMax    = 18'd51472;

  // Arctangent of 2^-i with 24 fraction bits.
  function automatic logic [24:0] atan_lut(input int unsigned i);
    logic [24:0] r;
    case (i)
      0:       r = 25'd13176795;
      1:       r = 25'd7778716;
      2:       r = 25'd4110060;
      3:       r = 25'd2086331;
      4:       r = 25'd1047214;
      5:       r = 25'd524117;
      6:       r = 25'd262123;
      7:       r = 25'd131069;
      default: r = 25'd65536 >> (i - 8);
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/vau_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, with sideband.
module vau_isqrt #(
  parameter int unsigned RootW = 24,
  parameter int unsigned SideW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [2*RootW-1:0]   rad_i,
  input  logic [SideW-1:0]     side_i,
  output logic                 valid_o,
  output logic [RootW-1:0]     root_o,
  output logic [SideW-1:0]     side_o
);
  localparam int unsigned RemW = RootW + 3;

  logic [RootW-1:0]   vld_q;
  logic [2*RootW-1:0] rad_q  [RootW];
  logic [RemW-1:0]    rem_q  [RootW];
  logic [RootW-1:0]   root_q [RootW];
  logic [SideW-1:0]   side_q [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [2*RootW-1:0] rad_p;
    logic [RemW-1:0]    rem_p, rem_s, trial;
    logic [RootW-1:0]   root_p;
    logic [SideW-1:0]   side_p;
    logic               vld_p, ge;

    if (k == 0) begin : g_first
      assign rad_p  = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign rad_p  = rad_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign side_p = side_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_s = {rem_p[RemW-3:0], rad_p[2*RootW-1-2*k -: 2]};
    assign trial = {1'b0, root_p, 2'b01};
    assign ge    = (rem_s >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_p;
        rem_q[k]  <= ge ? (rem_s - trial) : rem_s;
        root_q[k] <= {root_p[RootW-2:0], ge};
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

// ----- rtl/core/vector_angle_unit.sv -----
// Throughput: one request per cycle while the output is not stalled; the dot product, two 24-step square roots,
// a 15-step divider, a 15-step square root and 20 CORDIC steps each take one stage.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and sets the length threshold to 1.
module vector_angle_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  vau_pkg::vau_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vau_pkg::vau_rsp_t  out_rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i
);
  import vau_pkg::*;

  localparam int unsigned DivSteps = 15;

  logic adv;
  logic [31:0] thr_q;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv         = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 32'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  // Stage 1: component products.
  logic v1_q;
  logic signed [31:0] pxx_q, pyy_q, pzz_q, aa_x_q, aa_y_q, aa_z_q, bb_x_q, bb_y_q, bb_z_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pxx_q  <= in_req_i.first_x * in_req_i.second_x;
      pyy_q  <= in_req_i.first_y * in_req_i.second_y;
      pzz_q  <= in_req_i.first_z * in_req_i.second_z;
      aa_x_q <= in_req_i.first_x * in_req_i.first_x;
      aa_y_q <= in_req_i.first_y * in_req_i.first_y;
      aa_z_q <= in_req_i.first_z * in_req_i.first_z;
      bb_x_q <= in_req_i.second_x * in_req_i.second_x;
      bb_y_q <= in_req_i.second_y * in_req_i.second_y;
      bb_z_q <= in_req_i.second_z * in_req_i.second_z;
    end
  end

  // Stage 2: dot product and squared lengths.
  logic v2_q;
  logic signed [33:0] dot_q;
  logic [31:0] sqa_q, sqb_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dot_q <= 34'(pxx_q) + 34'(pyy_q) + 34'(pzz_q);
      sqa_q <= 32'(33'($unsigned(aa_x_q)) + 33'($unsigned(aa_y_q)) + 33'($unsigned(aa_z_q)));
      sqb_q <= 32'(33'($unsigned(bb_x_q)) + 33'($unsigned(bb_y_q)) + 33'($unsigned(bb_z_q)));
    end
  end

  // Lengths with 16 fraction bits.
  logic [31:0] mdot_in;
  logic        va_s, vb_s, neg_s;
  logic [23:0] lena_s, lenb_s;
  logic [31:0] mdot_s;

  assign mdot_in = dot_q[33] ? 32'(-dot_q) : dot_q[31:0];

  vau_isqrt #(.RootW(24), .SideW(32)) u_sqrt_a (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v2_q),
    .rad_i({sqa_q, 16'b0}), .side_i(mdot_in),
    .valid_o(va_s), .root_o(lena_s), .side_o(mdot_s)
  );

  vau_isqrt #(.RootW(24), .SideW(1)) u_sqrt_b (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v2_q),
    .rad_i({sqb_q, 16'b0}), .side_i(dot_q[33]),
    .valid_o(vb_s), .root_o(lenb_s), .side_o(neg_s)
  );

  // Stage 3: product of lengths.
  logic v3_q, neg3_q;
  logic [47:0] mag3_q;
  logic [31:0] mdot3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag3_q  <= lena_s * lenb_s;
      mdot3_q <= mdot_s;
      neg3_q  <= neg_s;
    end
  end

  // Stage 4: rounded dividend, degenerate test and early saturation.
  logic v4_q, neg4_q, deg4_q, sat4_q;
  logic [62:0] num4_q;
  logic [47:0] mag4_q;
  logic [62:0] num_s;

  assign num_s = ({31'b0, mdot3_q} << 30) + 63'(mag3_q >> 1);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num4_q <= num_s;
      mag4_q <= mag3_q;
      neg4_q <= neg3_q;
      deg4_q <= (mag3_q == '0) || (mag3_q < {thr_q, 16'b0});
      sat4_q <= num_s >= ({15'b0, mag3_q} << DivSteps);
    end
  end

  // Restoring divider, one quotient bit per stage.
  logic [DivSteps-1:0] dv_q;
  logic [62:0] drem_q [DivSteps];
  logic [47:0] dmag_q [DivSteps];
  logic [CosW-1:0] dquo_q [DivSteps];
  logic [DivSteps-1:0] dsat_q, ddeg_q, dneg_q;

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    logic [62:0] rem_p, sub;
    logic [47:0] mag_p;
    logic [CosW-1:0] quo_p;
    logic vld_p, sat_p, deg_p, neg_p, ge;

    if (j == 0) begin : g_first
      assign rem_p = num4_q;
      assign mag_p = mag4_q;
      assign quo_p = '0;
      assign vld_p = v4_q;
      assign sat_p = sat4_q;
      assign deg_p = deg4_q;
      assign neg_p = neg4_q;
    end else begin : g_next
      assign rem_p = drem_q[j-1];
      assign mag_p = dmag_q[j-1];
      assign quo_p = dquo_q[j-1];
      assign vld_p = dv_q[j-1];
      assign sat_p = dsat_q[j-1];
      assign deg_p = ddeg_q[j-1];
      assign neg_p = dneg_q[j-1];
    end

    assign sub = {15'b0, mag_p} << (DivSteps - 1 - j);
    assign ge  = (rem_p >= sub);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (adv) begin
        dv_q[j] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        drem_q[j] <= ge ? (rem_p - sub) : rem_p;
        dmag_q[j] <= mag_p;
        dquo_q[j] <= {quo_p[CosW-2:0], ge};
        dsat_q[j] <= sat_p;
        ddeg_q[j] <= deg_p;
        dneg_q[j] <= neg_p;
      end
    end
  end

  // Stage 5: clamp cosine magnitude to one.
  logic v5_q, neg5_q, deg5_q;
  logic [CosW-1:0] cmag5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmag5_q <= (dsat_q[DivSteps-1] || dquo_q[DivSteps-1] > CosOne) ? CosOne
                                                                    : dquo_q[DivSteps-1];
      neg5_q  <= dneg_q[DivSteps-1];
      deg5_q  <= ddeg_q[DivSteps-1];
    end
  end

  // Stage 6: one minus cosine squared.
  logic v6_q, neg6_q, deg6_q;
  logic [CosW-1:0] cmag6_q;
  logic [29:0] rad6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad6_q  <= 30'(29'h1000_0000 - 29'(cmag5_q * cmag5_q));
      cmag6_q <= cmag5_q;
      neg6_q  <= neg5_q;
      deg6_q  <= deg5_q;
    end
  end

  // Sine by square root.
  logic vs_s;
  logic [14:0] sin_s;
  logic [CosW+1:0] side_s;

  vau_isqrt #(.RootW(15), .SideW(CosW + 2)) u_sqrt_sin (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v6_q),
    .rad_i(rad6_q), .side_i({deg6_q, neg6_q, cmag6_q}),
    .valid_o(vs_s), .root_o(sin_s), .side_o(side_s)
  );

  // CORDIC vectoring, one rotation per stage.
  logic [CordicSteps-1:0] cv_q, cdeg_q, cneg_q;
  logic signed [33:0] cx_q [CordicSteps];
  logic signed [33:0] cy_q [CordicSteps];
  logic signed [26:0] cz_q [CordicSteps];

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    logic signed [33:0] x_p, y_p, dx, dy;
    logic signed [26:0] z_p, at;
    logic vld_p, deg_p, neg_p, up;

    if (i == 0) begin : g_first
      assign x_p   = $signed({3'b0, side_s[CosW-1:0], 16'b0});
      assign y_p   = $signed({3'b0, sin_s, 16'b0});
      assign z_p   = '0;
      assign vld_p = vs_s;
      assign deg_p = side_s[CosW+1];
      assign neg_p = side_s[CosW];
    end else begin : g_next
      assign x_p   = cx_q[i-1];
      assign y_p   = cy_q[i-1];
      assign z_p   = cz_q[i-1];
      assign vld_p = cv_q[i-1];
      assign deg_p = cdeg_q[i-1];
      assign neg_p = cneg_q[i-1];
    end

    assign dx = y_p >>> i;
    assign dy = x_p >>> i;
    assign at = $signed({2'b0, atan_lut(i)});
    assign up = !y_p[33] && (y_p != '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i] <= 1'b0;
      end else if (adv) begin
        cv_q[i] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cx_q[i]   <= up ? (x_p + dx) : (x_p - dx);
        cy_q[i]   <= up ? (y_p - dy) : (y_p + dy);
        cz_q[i]   <= up ? (z_p + at) : (z_p - at);
        cdeg_q[i] <= deg_p;
        cneg_q[i] <= neg_p;
      end
    end
  end

  // Stage F: fold into the upper half plane for a negative cosine.
  logic vf_q, degf_q;
  logic signed [27:0] angf_q;
  logic signed [27:0] zc, af;

  always_comb begin
    zc = cz_q[CordicSteps-1][26] ? 28'sd0 : 28'(cz_q[CordicSteps-1]);
    af = cneg_q[CordicSteps-1] ? (PiAng - zc) : zc;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      angf_q <= af[27] ? 28'sd0 : af;
      degf_q <= cdeg_q[CordicSteps-1];
    end
  end

  // Output register: round to 14 fraction bits and cap, or give zero for a degenerate request.
  logic vo_q;
  vau_rsp_t rsp_q;
  logic [17:0] rnd;

  assign rnd = 18'((angf_q[26:0] + 27'd512) >> 10);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp_q.degenerate <= degf_q;
      rsp_q.angle      <= degf_q ? 16'd0 : ((rnd > AngleMax) ? AngleMax[15:0] : rnd[15:0]);
    end
  end

  // Valid bits of the fixed stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      vf_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= va_s;
      v4_q <= v3_q;
      v5_q <= dv_q[DivSteps-1];
      v6_q <= v5_q;
      vf_q <= cv_q[CordicSteps-1];
      vo_q <= vf_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_rsp_o   = rsp_q;

`include "vector_angle_unit_assert.svh"

  `VAU_ASSERT(a_len_lanes, va_s == vb_s, "length lanes out of step")
  `VAU_ASSERT_IMPL(a_deg_zero, vo_q && rsp_q.degenerate, rsp_q.angle == '0, "angle not zero")
  `VAU_ASSERT_IMPL(a_angle_cap, out_valid_o, out_rsp_o.angle <= AngleMax[15:0], "angle above pi")
  `VAU_ASSERT_IMPL(a_cos_one, v6_q, cmag6_q <= CosOne, "cosine beyond one")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the vector angle unit: predicts each angle and compares it.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vau_pkg::*;

  localparam int unsigned RandItems = 1750;
  localparam longint unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 100;

  // Arctangent of 2^-i with 24 fraction bits, used by the angle predictor.
  localparam longint AtanTab [20] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
  localparam longint PiFix = 52707179;
  localparam longint AngleCap = 51472;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  vau_req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  vau_rsp_t out_rsp_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  vau_rsp_t angle_queue[$];
  logic [31:0] threshold;
  int unsigned mismatches = 0;
  longint unsigned cycle_count = 0;
  bit hold_off = 1'b0;
  int unsigned rx_wait = 0;

  vector_angle_unit DUT (.*);

  // Clock: period 10 ns.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Ends a run that hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Integer square root, floor.
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Computes the expected angle response for one request.
  function automatic vau_rsp_t predict_angle(input vau_req_t r, input logic [31:0] thr);
    longint ax, ay, az, bx, by, bz, dot, x, y, z, dx, dy, ang;
    longint unsigned len_a, len_b, mag, mdot, cmag, sn;
    bit neg;
    vau_rsp_t res;
    ax = r.first_x; ay = r.first_y; az = r.first_z;
    bx = r.second_x; by = r.second_y; bz = r.second_z;
    dot = ax * bx + ay * by + az * bz;
    len_a = root_floor(longint'(ax * ax + ay * ay + az * az) << 16);
    len_b = root_floor(longint'(bx * bx + by * by + bz * bz) << 16);
    mag = len_a * len_b;
    res = '0;
    if (mag == 0 || mag < (longint'(thr) << 16)) begin
      res.degenerate = 1'b1;
      return res;
    end
    neg = dot < 0;
    mdot = neg ? -dot : dot;
    cmag = ((mdot << 30) + (mag >> 1)) / mag;
    if (cmag > 16384) cmag = 16384;
    sn = root_floor((64'd1 << 28) - cmag * cmag);
    x = cmag << 16;
    y = sn << 16;
    z = 0;
    // CORDIC vectoring with floor shifts.
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += AtanTab[i];
      end else begin
        x -= dx; y += dy; z -= AtanTab[i];
      end
    end
    ang = (z < 0) ? 0 : z;
    if (neg) ang = PiFix - ang;
    if (ang < 0) ang = 0;
    ang = (ang + (64'sd1 << 9)) >>> 10;
    if (ang > AngleCap) ang = AngleCap;
    res.angle = ang[15:0];
    return res;
  endfunction

  task automatic report(input string what, input vau_rsp_t got, input vau_rsp_t want);
    mismatches++;
    $display("mismatch %s: got angle %0d degenerate %0b, expected angle %0d degenerate %0b",
             what, got.angle, got.degenerate, want.angle, want.degenerate);
  endtask

  // Sends one request after a random gap and records its expected response.
  // Valid stays high into the next request when the gap is zero.
  task automatic send_request(input vau_req_t r);
    int unsigned gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_req_i <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    angle_queue.push_back(predict_angle(r, threshold));
    @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [31:0] v);
    in_valid_i <= 1'b0;
    while (angle_queue.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    threshold = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_comp(input int unsigned style);
    case (style)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 512)) - 256);
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($signed($urandom_range(0, 20)) - 10);
    endcase
  endfunction

  // Receiver: waits a drawn number of cycles before each response, or holds off.
  always @(negedge clk_i) begin
    if (hold_off) begin
      out_stall_i <= 1'b1;
    end else if (rx_wait != 0) begin
      out_stall_i <= 1'b1;
      rx_wait--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    vau_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rx_wait = $urandom_range(0, 5);
      if (angle_queue.size() == 0) begin
        report("unexpected response", out_rsp_o, '0);
      end else begin
        want = angle_queue.pop_front();
        if (out_rsp_o.angle !== want.angle) report("angle", out_rsp_o, want);
        else if (out_rsp_o.degenerate !== want.degenerate) report("degenerate", out_rsp_o, want);
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering requests.
  initial begin
    wait (rst_ni);
    repeat (3000) @(negedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(negedge clk_i);
    hold_off = 1'b0;
  end

  // Directed table: first vector, second vector, and a typed-in answer where obvious.
  typedef struct {
    vau_req_t req;
    bit known;
    vau_rsp_t rsp;
  } case_row_t;

  initial begin
    case_row_t rows[$];
    vau_req_t r;
    threshold = 32'd1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero vector, parallel, antiparallel, orthogonal, extremes.
    rows.push_back('{'{0, 0, 0, 256, 0, 0}, 1, '{16'd0, 1'b1}});
    rows.push_back('{'{256, 0, 0, 0, 0, 0}, 1, '{16'd0, 1'b1}});
    rows.push_back('{'{256, 0, 0, 512, 0, 0}, 1, '{16'd0, 1'b0}});
    rows.push_back('{'{256, 0, 0, -256, 0, 0}, 1, '{16'd51472, 1'b0}});
    rows.push_back('{'{256, 0, 0, 0, 256, 0}, 0, '0});
    rows.push_back('{'{-32768, -32768, -32768, -32768, -32768, -32768}, 1, '{16'd0, 1'b0}});
    rows.push_back('{'{32767, 32767, 32767, -32768, -32768, -32768}, 1, '{16'd51472, 1'b0}});
    rows.push_back('{'{32767, -32768, 32767, -32768, 32767, 1}, 0, '0});
    rows.push_back('{'{1, 0, 0, 0, 0, 1}, 0, '0});
    rows.push_back('{'{1, 1, 1, 1, 1, 1}, 0, '0});
    rows.push_back('{'{1, 0, 0, -1, 0, 0}, 0, '0});
    rows.push_back('{'{300, -700, 12, 5, 9, -1000}, 0, '0});
    rows.push_back('{'{-1, -1, -1, 1, 1, 1}, 0, '0});
    foreach (rows[i]) begin
      send_request(rows[i].req);
      if (rows[i].known && angle_queue[$] !== rows[i].rsp) begin
        report("table row", angle_queue[$], rows[i].rsp);
      end
    end

    // Threshold extremes: zero lets tiny vectors through, all ones makes all degenerate.
    write_threshold(32'd0);
    send_request('{0, 0, 0, 0, 0, 0});
    send_request('{1, 0, 0, 0, 1, 0});
    write_threshold(32'hFFFF_FFFF);
    send_request('{-32768, -32768, -32768, -32768, -32768, -32768});
    send_request('{100, 0, 0, 0, 100, 0});
    write_threshold(32'd1);

    // Random part across several thresholds.
    for (int unsigned n = 0; n < RandItems; n++) begin
      if (n % 350 == 349) begin
        case ($urandom_range(0, 3))
          0: write_threshold(32'd0);
          1: write_threshold($urandom_range(0, 65536));
          2: write_threshold($urandom);
          default: write_threshold(32'd1);
        endcase
      end
      r.first_x = rand_comp($urandom_range(0, 3));
      r.first_y = rand_comp($urandom_range(0, 3));
      r.first_z = rand_comp($urandom_range(0, 3));
      r.second_x = rand_comp($urandom_range(0, 3));
      r.second_y = rand_comp($urandom_range(0, 3));
      r.second_z = rand_comp($urandom_range(0, 3));
      // Sometimes make the second vector a negated or identical copy of the first.
      if ($urandom_range(0, 7) == 0) begin
        r.second_x = -r.first_x;
        r.second_y = -r.first_y;
        r.second_z = -r.first_z;
      end else if ($urandom_range(0, 7) == 0) begin
        r.second_x = r.first_x;
        r.second_y = r.first_y;
        r.second_z = r.first_z;
      end
      send_request(r);
    end
    in_valid_i <= 1'b0;

    // Drain and finish.
    while (angle_queue.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
